// ===== rtl/lnsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnsc_pkg
// Shared types and constants of the letterbox nearest-neighbour scaler.
// ----------------------------------------------------------------------------
package lnsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int PITCH_W    = 15;
    localparam int ADDR_W     = 26;
    localparam int PIX_W      = 32;

    localparam logic [PIX_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;
    localparam logic [4:0]       MASK_5       = 5'h1F;
    localparam logic [5:0]       MASK_6       = 6'h3F;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RGB32    = 3'd5;

    localparam logic CMD_LOCATE  = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    typedef enum logic [2:0] {
        G_IDLE,
        G_MUL,
        G_CMP,
        G_DIV,
        G_OFF
    } t_geo_state;

    // Side data that travels alongside the coordinate dividers
    typedef struct packed {
        logic             in_area;
        logic [PIX_W-1:0] pixel;
    } t_side;

endpackage

// ===== rtl/lnsc_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnsc_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lnsc_div_pipe #(
    parameter int NW = 25,
    parameter int DW = 13,
    parameter int QW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_vld,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [QW-1:0] r_q   [QW];
    logic [QW-1:0] r_v;

    logic [DW-1:0] p_rem [QW];
    logic [QW-1:0] p_lo  [QW];
    logic [QW-1:0] p_q   [QW];
    logic [DW-1:0] n_rem [QW];
    logic [QW-1:0] n_lo  [QW];
    logic [QW-1:0] n_q   [QW];

    always_comb begin
        logic [DW:0] t;
        logic        ge;
        p_rem[0] = DW'(i_num >> QW);
        p_lo[0]  = i_num[QW-1:0];
        p_q[0]   = '0;
        for (int s = 1; s < QW; s++) begin
            p_rem[s] = r_rem[s-1];
            p_lo[s]  = r_lo[s-1];
            p_q[s]   = r_q[s-1];
        end
        for (int s = 0; s < QW; s++) begin
            t        = {p_rem[s], p_lo[s][QW-1]};
            ge       = (t >= {1'b0, i_den});
            n_rem[s] = ge ? DW'(t - {1'b0, i_den}) : DW'(t);
            n_lo[s]  = {p_lo[s][QW-2:0], 1'b0};
            n_q[s]   = {p_q[s][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int s = 0; s < QW; s++) begin
                r_rem[s] <= n_rem[s];
                r_lo[s]  <= n_lo[s];
                r_q[s]   <= n_q[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[QW-2:0], i_vld};
        end
    end

    assign o_vld = r_v[QW-1];
    assign o_quo = r_q[QW-1];

endmodule

// ===== rtl/letterbox_nearest_scaler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letterbox_nearest_scaler_top
// Aspect-preserving, centred nearest-neighbour scaler: locates screen pixels
// in the source frame and converts raw source pixels to BGRA.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  input    in         i_valid / o_stall      i_command, i_screen_x/y, i_raw_pixel
//  output   out        o_valid / i_stall      o_in_content, o_source_address,
//                                             o_pixel_out
//  config   in         i_cfg_we               i_cfg_index, i_cfg_data
//
//  One word per clock while o_stall is low; each word passes 17 register
//  stages (range check, multiply, 13 divider stages, pitch multiply, address
//  add), the last of them the output register. The divider pipe sets the
//  latency.
//  After reset and after every configuration write the geometry sequencer
//  runs its multiply, compare, serial divide and offset states; o_stall is
//  held high meanwhile.
//  A stall while o_valid is high freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module letterbox_nearest_scaler_top #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [lnsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lnsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_command,
    input  logic [lnsc_pkg::COORD_W-1:0]      i_screen_x,
    input  logic [lnsc_pkg::COORD_W-1:0]      i_screen_y,
    input  logic [lnsc_pkg::PIX_W-1:0]        i_raw_pixel,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_in_content,
    output logic [lnsc_pkg::ADDR_W-1:0]       o_source_address,
    output logic [lnsc_pkg::PIX_W-1:0]        o_pixel_out
);

    import lnsc_pkg::*;

    localparam int QW        = DIM_W;
    localparam int NW        = COORD_W + DIM_W;
    localparam int GNUM_W    = 2 * DIM_W;
    localparam int GCNT_W    = $clog2(GNUM_W);
    localparam int PROD_W    = DIM_W + PITCH_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   r_scr_w, r_scr_h, r_src_w, r_src_h;
    logic [PITCH_W-1:0] r_pitch;
    logic               r_rgb32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= DIM_W'(1920);
            r_scr_h <= DIM_W'(720);
            r_src_w <= '0;
            r_src_h <= '0;
            r_pitch <= '0;
            r_rgb32 <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_W: r_scr_w <= i_cfg_data[DIM_W-1:0];
                CFG_SCREEN_H: r_scr_h <= i_cfg_data[DIM_W-1:0];
                CFG_SOURCE_W: r_src_w <= i_cfg_data[DIM_W-1:0];
                CFG_SOURCE_H: r_src_h <= i_cfg_data[DIM_W-1:0];
                CFG_PITCH:    r_pitch <= i_cfg_data;
                CFG_RGB32:    r_rgb32 <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Saturate dimensions at the supported maximum
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W:0] lim;
        lim = (DIM_W+1)'(MAX_DIMENSION);
        return ({1'b0, v} > lim) ? DIM_W'(lim) : v;
    endfunction

    logic [DIM_W-1:0] dw, dh, sw, sh;
    assign dw = sat_dim(r_scr_w);
    assign dh = sat_dim(r_scr_h);
    assign sw = sat_dim(r_src_w);
    assign sh = sat_dim(r_src_h);

    // ------------------------------------------------------------------
    // Geometry sequencer: fitted size and centring offsets
    // ------------------------------------------------------------------
    t_geo_state r_gstate, n_gstate;
    logic [GCNT_W-1:0] r_gcnt;
    logic [GNUM_W-1:0] r_pa, r_pb, r_gnum, r_gq;
    logic [DIM_W-1:0]  r_gden, r_grem;
    logic              r_gfit_w;
    logic [DIM_W-1:0]  r_offx, r_offy, r_ow, r_oh;
    logic [DIM_W:0]    r_endx, r_endy;
    logic              r_content;

    logic g_load_prod, g_load_div, g_step, g_load_off;

    always_comb begin
        n_gstate = r_gstate;
        case (r_gstate)
            G_IDLE: n_gstate = G_IDLE;
            G_MUL:  n_gstate = G_CMP;
            G_CMP:  n_gstate = G_DIV;
            G_DIV:  n_gstate = (r_gcnt == GCNT_W'(GNUM_W - 1)) ? G_OFF : G_DIV;
            G_OFF:  n_gstate = G_IDLE;
            default: n_gstate = G_IDLE;
        endcase
        // restart on any register write
        if (i_cfg_we) n_gstate = G_MUL;
    end

    always_comb begin
        g_load_prod = 1'b0;
        g_load_div  = 1'b0;
        g_step      = 1'b0;
        g_load_off  = 1'b0;
        case (r_gstate)
            G_MUL:   g_load_prod = 1'b1;
            G_CMP:   g_load_div  = 1'b1;
            G_DIV:   g_step      = 1'b1;
            G_OFF:   g_load_off  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gstate <= G_MUL;
        end else begin
            r_gstate <= n_gstate;
        end
    end

    logic [DIM_W:0]    g_t;
    logic              g_ge;
    logic [GNUM_W-1:0] g_q;
    logic [DIM_W-1:0]  g_qc, g_ow, g_oh;

    assign g_t  = {r_grem, r_gnum[GNUM_W-1]};
    assign g_ge = (g_t >= {1'b0, r_gden});

    always_comb begin
        g_q = r_gq;
        if (r_gfit_w) begin
            g_qc = (g_q > GNUM_W'(dh)) ? dh : DIM_W'(g_q);
            g_ow = dw;
            g_oh = g_qc;
        end else begin
            g_qc = (g_q > GNUM_W'(dw)) ? dw : DIM_W'(g_q);
            g_ow = g_qc;
            g_oh = dh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_load_prod) begin
            r_pa <= sw * dh;
            r_pb <= sh * dw;
        end
        if (g_load_div) begin
            r_gfit_w <= (r_pa > r_pb);
            r_gnum   <= (r_pa > r_pb) ? r_pb : r_pa;
            r_gden   <= (r_pa > r_pb) ? sw : sh;
            r_grem   <= '0;
            r_gq     <= '0;
            r_gcnt   <= '0;
        end
        if (g_step) begin
            r_grem <= g_ge ? DIM_W'(g_t - {1'b0, r_gden}) : DIM_W'(g_t);
            r_gnum <= {r_gnum[GNUM_W-2:0], 1'b0};
            r_gq   <= {r_gq[GNUM_W-2:0], g_ge};
            r_gcnt <= r_gcnt + 1'b1;
        end
        if (g_load_off) begin
            r_ow      <= g_ow;
            r_oh      <= g_oh;
            r_offx    <= DIM_W'((dw - g_ow) >> 1);
            r_offy    <= DIM_W'((dh - g_oh) >> 1);
            r_endx    <= (DIM_W+1)'(DIM_W'((dw - g_ow) >> 1)) + (DIM_W+1)'(g_ow);
            r_endy    <= (DIM_W+1)'(DIM_W'((dh - g_oh) >> 1)) + (DIM_W+1)'(g_oh);
            r_content <= (sw != '0) && (sh != '0) && (g_ow != '0) && (g_oh != '0);
        end
    end

    // ------------------------------------------------------------------
    // Word pipeline; the whole pipe advances unless the output is held
    // ------------------------------------------------------------------
    logic adv;
    logic r_ov;
    assign adv     = !(r_ov && i_stall);
    assign o_stall = (r_gstate != G_IDLE) || !adv;

    logic accept;
    assign accept = i_valid && !o_stall;

    function automatic logic [PIX_W-1:0] expand565(input logic [15:0] p);
        logic [4:0] r, b;
        logic [5:0] g;
        r = p[15:11] & MASK_5;
        g = p[10:5]  & MASK_6;
        b = p[4:0]   & MASK_5;
        return OPAQUE_BLACK | {8'h00, r, r[4:2], g, g[5:4], b, b[4:2]};
    endfunction

    // Stage 1: range test, offsets removed, pixel converted
    logic                inside_c;
    logic [DIM_W:0]      xe, ye;
    t_side               s1_side_c;

    assign xe = (DIM_W+1)'(i_screen_x);
    assign ye = (DIM_W+1)'(i_screen_y);
    assign inside_c = (i_command == CMD_LOCATE) && r_content
                   && (xe >= (DIM_W+1)'(r_offx)) && (xe < r_endx)
                   && (ye >= (DIM_W+1)'(r_offy)) && (ye < r_endy);

    always_comb begin
        s1_side_c.in_area = inside_c;
        if (i_command == CMD_CONVERT) begin
            s1_side_c.pixel = r_rgb32 ? (i_raw_pixel | OPAQUE_BLACK)
                                      : expand565(i_raw_pixel[15:0]);
        end else begin
            s1_side_c.pixel = inside_c ? '0 : OPAQUE_BLACK;
        end
    end

    logic               r1_v, r2_v;
    logic [COORD_W-1:0] r1_dx, r1_dy;
    t_side              r1_side, r2_side;
    logic [NW-1:0]      r2_nx, r2_ny;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_dx   <= COORD_W'(i_screen_x - COORD_W'(r_offx));
            r1_dy   <= COORD_W'(i_screen_y - COORD_W'(r_offy));
            r1_side <= s1_side_c;
            // Stage 2: scale by source size
            r2_nx   <= r1_side.in_area ? r1_dx * sw : '0;
            r2_ny   <= r1_side.in_area ? r1_dy * sh : '0;
            r2_side <= r1_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (adv) begin
            r1_v <= accept;
            r2_v <= r1_v;
        end
    end

    // Divide by the fitted size
    logic          dvx_v, dvy_v;
    logic [QW-1:0] sx, sy;

    lnsc_div_pipe #(.NW(NW), .DW(DIM_W), .QW(QW)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (r2_v),
        .i_num   (r2_nx),
        .i_den   (r_ow),
        .o_vld   (dvx_v),
        .o_quo   (sx)
    );

    lnsc_div_pipe #(.NW(NW), .DW(DIM_W), .QW(QW)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (r2_v),
        .i_num   (r2_ny),
        .i_den   (r_oh),
        .o_vld   (dvy_v),
        .o_quo   (sy)
    );

    // Hold side data in step with the dividers
    t_side r_sd [QW];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sd[0] <= r2_side;
            for (int s = 1; s < QW; s++) r_sd[s] <= r_sd[s-1];
        end
    end

    // Stage M: row offset multiply; stage O: address add into output register
    logic               r3_v;
    logic [PROD_W-1:0]  r3_prod;
    logic [QW+1:0]      r3_sxb;
    t_side              r3_side;
    logic [ADDR_W-1:0]  r_oaddr;
    t_side              r_oside;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_prod <= sy * r_pitch;
            r3_sxb  <= r_rgb32 ? {sx, 2'b00} : {1'b0, sx, 1'b0};
            r3_side <= r_sd[QW-1];
            r_oaddr <= r3_side.in_area ? ADDR_W'(r3_prod + PROD_W'(r3_sxb)) : '0;
            r_oside <= r3_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r3_v <= dvx_v && dvy_v;
            r_ov <= r3_v;
        end
    end

    assign o_valid          = r_ov;
    assign o_in_content     = r_oside.in_area;
    assign o_source_address = r_oaddr;
    assign o_pixel_out      = r_oside.pixel;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_border_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_content) |-> (o_source_address == '0))
        else $error("border word carries a source address");

    a_content_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_in_content) |-> (o_pixel_out == '0))
        else $error("content word carries a pixel value");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gstate != G_IDLE) |-> o_stall)
        else $error("word accepted while geometry is being computed");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (o_stall && (r_gstate == G_MUL)))
        else $error("register write did not restart geometry");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dvx_v == dvy_v)
        else $error("divider pipes out of step");

endmodule
